// ===== src/smbsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// smbsfe_pkg: shared types and constants of the structure string extractor
// Holds the register indexes, reset values and the structs that pass the
// configuration and one result between modules.
// ----------------------------------------------------------------------------
package smbsfe_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BUFFER_SIZE = 2'd2;

    localparam logic [7:0] RST_TARGET_TYPE     = 8'd0;
    localparam logic [7:0] RST_STRING_OFFSET   = 8'd4;
    localparam logic [7:0] RST_OUT_BUFFER_SIZE = 8'd64;

    localparam logic [7:0] HEADER_LEN = 8'd4;

    typedef struct packed {
        logic [7:0] target_type;
        logic [7:0] string_field_offset;
        logic [7:0] out_buffer_size;
    } smbsfe_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] char_byte;
        logic       char_valid;
        logic       done_res;
        logic       found;
    } smbsfe_res_t;

endpackage

// ===== src/smbsfe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// smbsfe_cfg_regs: configuration registers
// Plain indexed write port; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module smbsfe_cfg_regs
    import smbsfe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]           cfg_wdata,
    output smbsfe_cfg_t          cfg
);

    smbsfe_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_type         <= RST_TARGET_TYPE;
            cfg_reg.string_field_offset <= RST_STRING_OFFSET;
            cfg_reg.out_buffer_size     <= RST_OUT_BUFFER_SIZE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TARGET_TYPE:     cfg_reg.target_type         <= cfg_wdata;
                CFG_STRING_OFFSET:   cfg_reg.string_field_offset <= cfg_wdata;
                CFG_OUT_BUFFER_SIZE: cfg_reg.out_buffer_size     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/smbsfe_parser.sv =====
// ----------------------------------------------------------------------------
// smbsfe_parser: table walker
// Holds the parse state and works out, for the byte at its input, the result
// and the next state; the state advances when step is high.
// ----------------------------------------------------------------------------
module smbsfe_parser
    import smbsfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  smbsfe_cfg_t cfg,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        step,
    output smbsfe_res_t res
);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_STR,
        PH_WAIT
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [7:0] pos_reg,     pos_next;
    logic [7:0] len_reg,     len_next;
    logic [7:0] type_reg,    type_next;
    logic       match_reg,   match_next;
    logic [7:0] wanted_reg,  wanted_next;
    logic [7:0] passed_reg,  passed_next;
    logic       prevz_reg,   prevz_next;
    logic [7:0] emitted_reg, emitted_next;
    logic       answer_reg,  answer_next;

    logic       emit_char;
    logic       emit_done;
    logic       found_bit;
    logic [7:0] end_pos;
    logic [7:0] limit;
    logic       at_start;
    logic       is_zero;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        match_next   = match_reg;
        wanted_next  = wanted_reg;
        passed_next  = passed_reg;
        prevz_next   = prevz_reg;
        emitted_next = emitted_reg;
        answer_next  = answer_reg;
        emit_char    = 1'b0;
        emit_done    = 1'b0;
        found_bit    = 1'b0;
        is_zero      = (in_byte == 8'd0);
        at_start     = (pos_reg == 8'd0) || prevz_reg;
        limit        = cfg.out_buffer_size - 8'd1;
        end_pos      = HEADER_LEN;

        case (phase_reg)
            PH_HEAD: begin
                if (pos_reg == 8'd0) type_next = in_byte;
                if (pos_reg == 8'd1) len_next = in_byte;
                if (pos_reg == cfg.string_field_offset) wanted_next = in_byte;
                end_pos = (len_next < HEADER_LEN) ? HEADER_LEN : len_next;
                if (pos_reg >= 8'd3 && ({1'b0, pos_reg} + 9'd1) >= {1'b0, end_pos}) begin
                    match_next   = (type_next == cfg.target_type) &&
                                   (len_next > cfg.string_field_offset) &&
                                   (cfg.out_buffer_size != 8'd0);
                    phase_next   = PH_STR;
                    pos_next     = 8'd0;
                    prevz_next   = 1'b0;
                    passed_next  = 8'd0;
                    emitted_next = 8'd0;
                end else begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_STR: begin
                if (match_reg) begin
                    if (wanted_reg == 8'd0) begin
                        emit_done = 1'b1;
                    end else if (passed_reg == wanted_reg - 8'd1) begin
                        if (is_zero || emitted_reg >= limit) begin
                            emit_done = 1'b1;
                        end else begin
                            emit_char    = 1'b1;
                            emitted_next = emitted_reg + 8'd1;
                        end
                    end else if (is_zero) begin
                        if (at_start) emit_done = 1'b1;
                        else passed_next = passed_reg + 8'd1;
                    end
                    found_bit  = emit_done;
                    prevz_next = is_zero;
                    pos_next   = 8'd1;
                end else if (is_zero && prevz_reg && pos_reg != 8'd0) begin
                    // double zero closes the string set
                    phase_next  = PH_HEAD;
                    pos_next    = 8'd0;
                    len_next    = 8'd0;
                    type_next   = 8'd0;
                    wanted_next = 8'd0;
                    prevz_next  = 1'b0;
                    match_next  = 1'b0;
                end else begin
                    prevz_next = is_zero;
                    pos_next   = 8'd1;
                end
            end
            default: ;
        endcase

        if (emit_done) begin
            answer_next = 1'b1;
            phase_next  = PH_WAIT;
        end

        if (in_last) begin
            if (!answer_next) begin
                emit_char = 1'b0;
                emit_done = 1'b1;
                found_bit = match_next;
            end
            phase_next   = PH_HEAD;
            pos_next     = 8'd0;
            len_next     = 8'd0;
            type_next    = 8'd0;
            match_next   = 1'b0;
            wanted_next  = 8'd0;
            passed_next  = 8'd0;
            prevz_next   = 1'b0;
            emitted_next = 8'd0;
            answer_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            pos_reg     <= 8'd0;
            len_reg     <= 8'd0;
            type_reg    <= 8'd0;
            match_reg   <= 1'b0;
            wanted_reg  <= 8'd0;
            passed_reg  <= 8'd0;
            prevz_reg   <= 1'b0;
            emitted_reg <= 8'd0;
            answer_reg  <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            match_reg   <= match_next;
            wanted_reg  <= wanted_next;
            passed_reg  <= passed_next;
            prevz_reg   <= prevz_next;
            emitted_reg <= emitted_next;
            answer_reg  <= answer_next;
        end
    end

    always_comb begin
        res.valid      = emit_char || emit_done;
        res.char_byte  = emit_char ? in_byte : 8'd0;
        res.char_valid = emit_char;
        res.done_res   = emit_done && !emit_char;
        res.found      = emit_done && !emit_char && found_bit;
    end

endmodule

// ===== src/smbios_string_field_extractor.sv =====
// ----------------------------------------------------------------------------
// smbios_string_field_extractor: structure table string lookup
// Path: an accepted table byte is held in the input register, then its parser
// result is stored in the result register that drives m_.
// Throughput: one table byte per cycle unless m_tready holds back a result.
// Reset: synchronous active-low aresetn clears the parser, the valid flags of
// both pipeline registers and loads defaults (type 0, offset 4, buffer 64).
// ----------------------------------------------------------------------------
module smbios_string_field_extractor
    import smbsfe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // table_byte
    input  logic                 s_tlast,   // table_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // char_byte
    output logic [1:0]           m_tuser,   // found, char_valid
    output logic                 m_tlast    // done_res
);

    smbsfe_cfg_t cfg;
    smbsfe_res_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [1:0] out_user_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       advance;

    smbsfe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    smbsfe_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .step    (advance),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_char_reg <= res.char_byte;
            out_user_reg <= {res.found, res.char_valid};
            out_last_reg <= res.done_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // output register empties after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a character result never closes the answer, found only with done
    a_char_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tlast) && (!m_tuser[1] || m_tlast))
        else $error("bad result flag combination");

    // a held request keeps its byte while the parser waits
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled request lost");

    // parser steps with a result only when the result register has room
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.valid |-> out_free)
        else $error("result register overrun");

endmodule
